/* rtl/bps_pkg.sv */
`timescale 1ns / 1ps

package bps_pkg;

   // Pattern storage: 31 bytes from four configuration words.
   localparam int PAT_BYTES       = 31;
   localparam int PAT_BITS        = PAT_BYTES * 8;
   localparam int LEN_W           = 5;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 64;
   localparam int DEF_MAX_PATTERN = 31;
   localparam int DEF_ADDR_WIDTH  = 48;
   localparam int BASE_REG_BITS   = 48;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_PATTERN_0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PATTERN_1 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_PATTERN_2 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_PATTERN_3 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_LENGTH    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_BASE      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_FIND_LAST = 3'd6;

   localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

   typedef struct packed {
      logic [PAT_BITS-1:0] pattern;
      logic [LEN_W-1:0]    length;     // already capped to the window depth
      logic                find_last;
   } pat_cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } stage_type;

endpackage

/* rtl/bps_csr.sv */
`timescale 1ns / 1ps

module bps_csr import bps_pkg::*; #(
   parameter int MAX_PATTERN   = DEF_MAX_PATTERN,
   parameter int ADDRESS_WIDTH = DEF_ADDR_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_W-1:0]    csr_addr,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output pat_cfg_type              cfg,
   output logic [ADDRESS_WIDTH-1:0] start_offset
);

   localparam int BASE_BITS = (ADDRESS_WIDTH < BASE_REG_BITS) ? ADDRESS_WIDTH : BASE_REG_BITS;
   localparam logic [ADDRESS_WIDTH-1:0] BASE_MASK =
      {ADDRESS_WIDTH{1'b1}} >> (ADDRESS_WIDTH - BASE_BITS);
   localparam logic [LEN_W-1:0] LEN_CAP =
      (MAX_PATTERN > PAT_BYTES) ? LEN_W'(PAT_BYTES) : LEN_W'(MAX_PATTERN);

   logic [PAT_BITS-1:0]      pattern_ff;
   logic [LEN_W-1:0]         length_ff;
   logic [ADDRESS_WIDTH-1:0] base_ff;
   logic                     find_last_ff;
   logic [ADDRESS_WIDTH-1:0] offset_ff;
   logic [ADDRESS_WIDTH-1:0] offset_in;
   logic [LEN_W-1:0]         len_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= '0;
         length_ff    <= LEN_RESET;
         base_ff      <= '0;
         find_last_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_PATTERN_0: pattern_ff[63:0]    <= csr_wdata;
            REG_PATTERN_1: pattern_ff[127:64]  <= csr_wdata;
            REG_PATTERN_2: pattern_ff[191:128] <= csr_wdata;
            REG_PATTERN_3: pattern_ff[247:192] <= csr_wdata[55:0];
            REG_LENGTH:    length_ff           <= csr_wdata[LEN_W-1:0];
            REG_BASE:      base_ff             <= csr_wdata[ADDRESS_WIDTH-1:0] & BASE_MASK;
            REG_FIND_LAST: find_last_ff        <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign len_eff   = (length_ff > LEN_CAP) ? LEN_CAP : length_ff;
   // Precompute base minus length so the match address is a single add.
   assign offset_in = base_ff - ADDRESS_WIDTH'(len_eff);

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
   end

   assign cfg.pattern   = pattern_ff;
   assign cfg.length    = len_eff;
   assign cfg.find_last = find_last_ff;
   assign start_offset  = offset_ff;

endmodule

/* rtl/bps_window.sv */
`timescale 1ns / 1ps

module bps_window import bps_pkg::*; #(
   parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
   input  logic        clock,
   input  pat_cfg_type cfg,
   input  logic [7:0]  data_byte,
   input  logic        shift_en,
   output logic        pattern_ok
);

   logic [7:0] win_ff [MAX_PATTERN];
   logic [7:0] win_in [MAX_PATTERN];
   logic [7:0] pat_arr [2**LEN_W];
   logic [MAX_PATTERN-1:0] byte_ok;

   always_comb begin
      for (int i = 0; i < 2**LEN_W; i++) begin
         pat_arr[i] = 8'h00;
      end
      for (int i = 0; i < PAT_BYTES; i++) begin
         pat_arr[i] = cfg.pattern[i*8 +: 8];
      end
   end

   // Newest byte at tap 0.
   always_comb begin
      win_in[0] = data_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         win_in[k] = win_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         win_ff <= win_in;
      end
   end

   // Tap k holds the byte that must equal pattern byte length-1-k.
   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (k < int'(cfg.length)) begin
            byte_ok[k] = (win_in[k] == pat_arr[cfg.length - LEN_W'(k) - LEN_W'(1)]);
         end else begin
            byte_ok[k] = 1'b1;
         end
      end
   end

   assign pattern_ok = (cfg.length != '0) && (&byte_ok);

endmodule

/* rtl/bps_tracker.sv */
`timescale 1ns / 1ps

module bps_tracker import bps_pkg::*; #(
   parameter int ADDRESS_WIDTH = DEF_ADDR_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  stage_type                item,
   input  logic                     advance,
   input  pat_cfg_type              cfg,
   input  logic [ADDRESS_WIDTH-1:0] start_offset,
   input  logic                     pattern_ok,
   output logic                     shift_en,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic                     found,
   output logic [ADDRESS_WIDTH-1:0] match_address
);

   localparam logic [ADDRESS_WIDTH-1:0] SEEN_MAX = {ADDRESS_WIDTH{1'b1}};

   logic [ADDRESS_WIDTH-1:0] seen_ff, seen_in, seen_next;
   logic [ADDRESS_WIDTH-1:0] best_ff, best_in, hit_addr;
   logic                     have_ff, have_in;
   logic                     reported_ff, reported_in;
   logic                     valid_ff, valid_in;
   logic                     found_ff, found_in;
   logic [ADDRESS_WIDTH-1:0] addr_ff, addr_in;
   logic                     hit;

   assign shift_en  = advance && !reported_ff;
   assign seen_next = (seen_ff < SEEN_MAX) ? seen_ff + 1'b1 : seen_ff;
   assign hit       = pattern_ok && (seen_next >= ADDRESS_WIDTH'(cfg.length));
   assign hit_addr  = start_offset + seen_next;

   always_comb begin
      seen_in     = seen_ff;
      best_in     = best_ff;
      have_in     = have_ff;
      reported_in = reported_ff;
      valid_in    = valid_ff && !rsp_tready;
      found_in    = found_ff;
      addr_in     = addr_ff;
      if (advance) begin
         if (!reported_ff) begin
            seen_in = seen_next;
            if (hit) begin
               best_in = hit_addr;
               have_in = 1'b1;
            end
         end
         if (shift_en && hit && !cfg.find_last) begin
            // First-match mode: report at once, ignore the rest of the window.
            valid_in    = 1'b1;
            found_in    = 1'b1;
            addr_in     = hit_addr;
            reported_in = 1'b1;
         end else if (item.last && !reported_ff) begin
            valid_in = 1'b1;
            found_in = have_in;
            addr_in  = have_in ? best_in : '0;
         end
         if (item.last) begin
            seen_in     = '0;
            best_in     = '0;
            have_in     = 1'b0;
            reported_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         best_ff     <= '0;
         have_ff     <= 1'b0;
         reported_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         seen_ff     <= seen_in;
         best_ff     <= best_in;
         have_ff     <= have_in;
         reported_ff <= reported_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      addr_ff  <= addr_in;
   end

   assign rsp_tvalid    = valid_ff;
   assign found         = found_ff;
   assign match_address = addr_ff;

`ifndef ASSERT_OFF
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !found_ff) |-> (addr_ff == '0))
      else $error("not-found result carries a nonzero address");

   a_reported_has_match: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> have_ff)
      else $error("window marked answered without a recorded match");

   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(advance))
      else $error("result appeared without an item");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!valid_ff && !reported_ff && !have_ff))
      else $error("state not cleared by reset");
`endif

endmodule

/* rtl/byte_pattern_search_core.sv */
`timescale 1ns / 1ps

// Exact byte pattern search over a streamed window. Bytes of the window
// arrive one item per cycle on req_, lowest address first, with req_tlast on
// the final byte. The last MAX_PATTERN bytes are held in a shift line and
// compared in parallel against the configured pattern (1 to 31 bytes, a
// length of 0 never matches). In first-match mode (find_last = 0) the start
// address of the earliest match is reported on the item that completes it,
// and the rest of the window is dropped. In last-match mode the highest
// match is reported with the tlast item; a window with no match gives
// found = 0 and address 0. Throughput is one item per clock while the result
// stream keeps taking results: an accepted item waits in the input register,
// and once the result register is free the compare, address add and state
// update run into it. A result that waits holds the input register, so one
// more item is taken and then req_tready drops. Write configuration only
// while no item is in flight; the base address minus length is re-registered
// in the cycle after a write.
module byte_pattern_search_core import bps_pkg::*; #(
   parameter int MAX_PATTERN   = DEF_MAX_PATTERN,
   parameter int ADDRESS_WIDTH = DEF_ADDR_WIDTH,
   localparam int RSP_W        = ((ADDRESS_WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // end_of_window
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // [ADDRESS_WIDTH-1:0] match_address, zero fill
   output logic                  rsp_tuser    // found
);

   pat_cfg_type              cfg;
   logic [ADDRESS_WIDTH-1:0] start_offset;
   stage_type                stage_ff;
   stage_type                stage_in;
   logic                     out_free;
   logic                     advance;
   logic                     shift_en;
   logic                     pattern_ok;
   logic                     found;
   logic [ADDRESS_WIDTH-1:0] match_address;

   bps_csr #(
      .MAX_PATTERN  (MAX_PATTERN),
      .ADDRESS_WIDTH(ADDRESS_WIDTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .start_offset(start_offset)
   );

   // The result register can take a new result when it is empty or being
   // drained this cycle; only then does the held item advance.
   assign out_free   = !rsp_tvalid || rsp_tready;
   assign advance    = stage_ff.valid && out_free;
   // Accept a new item whenever the input register is empty or moving on,
   // even while a finished result still waits downstream.
   assign req_tready = !stage_ff.valid || out_free;

   always_comb begin
      stage_in = stage_ff;
      if (req_tvalid && req_tready) begin
         stage_in.valid = 1'b1;
         stage_in.data  = req_tdata;
         stage_in.last  = req_tlast;
      end else if (advance) begin
         stage_in.valid = 1'b0;
      end
   end

   // Reset only the valid bit; hold the payload without reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.data <= stage_in.data;
      stage_ff.last <= stage_in.last;
   end

   bps_window #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_window (
      .clock     (clock),
      .cfg       (cfg),
      .data_byte (stage_ff.data),
      .shift_en  (shift_en),
      .pattern_ok(pattern_ok)
   );

   bps_tracker #(
      .ADDRESS_WIDTH(ADDRESS_WIDTH)
   ) u_tracker (
      .clock        (clock),
      .reset        (reset),
      .item         (stage_ff),
      .advance      (advance),
      .cfg          (cfg),
      .start_offset (start_offset),
      .pattern_ok   (pattern_ok),
      .shift_en     (shift_en),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .found        (found),
      .match_address(match_address)
   );

   assign rsp_tdata = RSP_W'(match_address);
   assign rsp_tuser = found;

endmodule

/* tb/match_checker.sv */
`timescale 1ns / 1ps

module match_checker import bps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [DEF_ADDR_WIDTH-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  drain_done,
   output int                    pending,
   output int                    mismatches
);

   localparam int ADDR_W  = DEF_ADDR_WIDTH;
   localparam int MAX_PAT = DEF_MAX_PATTERN;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] address;
   } match_result_type;

   match_result_type expected_matches[$];

   // register copies
   logic [PAT_BITS-1:0] pattern_vec;
   logic [LEN_W-1:0]    match_length;
   logic [ADDR_W-1:0]   base_addr;
   logic                last_mode;

   // window state
   logic [7:0]        window_bytes [MAX_PAT];
   logic [ADDR_W-1:0] bytes_in_window;
   logic [ADDR_W-1:0] latest_start;
   logic              have_match;
   logic              window_answered;
   logic              drain_checked = 1'b0;

   initial mismatches = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic clear_window();
      int k;
      for (k = 0; k < MAX_PAT; k++) window_bytes[k] = 8'h00;
      bytes_in_window = '0;
      latest_start    = '0;
      have_match      = 1'b0;
      window_answered = 1'b0;
   endtask

   // Shift one byte into the window and queue whatever result it causes.
   task automatic search_byte(input logic [7:0] data, input logic last);
      logic hit;
      logic done_here;
      int   k;
      int   len;
      done_here = 1'b0;
      len       = int'(match_length);
      if (!window_answered) begin
         for (k = MAX_PAT - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
         window_bytes[0] = data;
         if (bytes_in_window != '1) bytes_in_window = bytes_in_window + 1'b1;
         hit = (len != 0) && (bytes_in_window >= ADDR_W'(len));
         for (k = 0; k < len; k++)
            if (window_bytes[k] != pattern_vec[(len - 1 - k) * 8 +: 8]) hit = 1'b0;
         if (hit) begin
            latest_start = base_addr + bytes_in_window - ADDR_W'(len);
            have_match   = 1'b1;
            if (!last_mode) begin
               expected_matches.push_back(match_result_type'{1'b1, latest_start});
               done_here = 1'b1;
               if (last) clear_window();
               else window_answered = 1'b1;
            end
         end
      end
      if (last && !done_here) begin
         if (!window_answered)
            expected_matches.push_back(
               match_result_type'{have_match, have_match ? latest_start : '0});
         clear_window();
      end
   endtask

   always @(posedge clock) begin
      match_result_type want;
      if (reset) begin
         pattern_vec  = '0;
         match_length = LEN_RESET;
         base_addr    = '0;
         last_mode    = 1'b0;
         clear_window();
         expected_matches.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_PATTERN_0: pattern_vec[63:0]    = csr_wdata;
               REG_PATTERN_1: pattern_vec[127:64]  = csr_wdata;
               REG_PATTERN_2: pattern_vec[191:128] = csr_wdata;
               REG_PATTERN_3: pattern_vec[247:192] = csr_wdata[55:0];
               REG_LENGTH:    match_length         = csr_wdata[LEN_W-1:0];
               REG_BASE:      base_addr            = csr_wdata[ADDR_W-1:0];
               REG_FIND_LAST: last_mode            = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_matches.size() == 0) begin
               report_mismatch($sformatf("unexpected result found=%0b address=%h",
                                         rsp_tuser, rsp_tdata));
            end else begin
               want = expected_matches.pop_front();
               if (rsp_tuser !== want.found)
                  report_mismatch($sformatf("found %0b, want %0b", rsp_tuser, want.found));
               if (rsp_tdata !== want.address)
                  report_mismatch($sformatf("address %h, want %h", rsp_tdata, want.address));
            end
         end
         if (req_tvalid && req_tready) search_byte(req_tdata, req_tlast);
         if (drain_done && !drain_checked) begin
            drain_checked = 1'b1;
            if (expected_matches.size() != 0)
               report_mismatch($sformatf("%0d results never arrived",
                                         expected_matches.size()));
         end
      end
      pending = expected_matches.size();
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
   import bps_pkg::*;

   localparam int ADDR_W           = DEF_ADDR_WIDTH;
   localparam int LATENCY          = 6;      // cycles past the last result
   localparam int DRAIN_LIMIT      = 4000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int NUM_PHASES       = 10;
   localparam int PHASE_ITEMS      = 30;
   localparam int PRESSURE_ITEMS   = 40;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;   // [7:0] data_byte
   logic                  req_tlast  = 1'b0;    // end_of_window
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [ADDR_W-1:0]     rsp_tdata;            // [47:0] match_address
   logic                  rsp_tuser;            // found
   logic                  drain_done = 1'b0;
   int                    pending;
   int                    mismatches;

   // sender and receiver pacing
   int         burst_left   = 0;
   bit         sender_gaps  = 1'b1;
   bit         rsp_stall_on = 1'b1;
   bit         long_hold    = 1'b0;
   logic [7:0] alphabet [4];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   byte_pattern_search_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   match_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .drain_done (drain_done),
      .pending    (pending),
      .mismatches (mismatches)
   );

   // Offer one item from a falling edge and hold it until the rising edge
   // that takes it. A new burst may start with a gap of idle cycles.
   task automatic send_item(input logic [7:0] data, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (sender_gaps) begin
            gap = $urandom_range(0, 10);
            repeat (gap) begin
               req_tvalid <= 1'b0;
               @(negedge clock);
            end
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid, let every expected result arrive, then let the pipe empty.
   task automatic wait_idle();
      int n;
      req_tvalid <= 1'b0;
      for (n = 0; n < DRAIN_LIMIT && pending != 0; n++) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // Release the write port and give the block time to re-register.
   task automatic settle_config();
      csr_we <= 1'b0;
      repeat (4) @(negedge clock);
   endtask

   task automatic load_config(input logic [255:0] pv, input logic [63:0] len_w,
                              input logic [63:0] base_w, input logic [63:0] mode_w);
      write_reg(REG_PATTERN_0, pv[63:0]);
      write_reg(REG_PATTERN_1, pv[127:64]);
      write_reg(REG_PATTERN_2, pv[191:128]);
      write_reg(REG_PATTERN_3, pv[255:192]);
      write_reg(REG_LENGTH, len_w);
      write_reg(REG_BASE, base_w);
      write_reg(REG_FIND_LAST, mode_w);
      settle_config();
   endtask

   // Half the bytes come from a small per-phase alphabet so partial and
   // overlapping matches show up on their own.
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 1) == 1) return alphabet[$urandom_range(0, 3)];
      return 8'($urandom);
   endfunction

   // Receiver: ready and stall runs of random length; on request, hold off
   // for a long stretch so the block backs up into its input.
   initial begin : receiver
      int run;
      int held;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < LONG_HOLD_CYCLES; held++) @(negedge clock);
            long_hold = 1'b0;
         end else if (!rsp_stall_on || $urandom_range(0, 3) != 0) begin
            run = $urandom_range(1, 12);
            rsp_tready <= 1'b1;
            repeat (run) @(negedge clock);
         end else begin
            run = $urandom_range(1, 6);
            rsp_tready <= 1'b0;
            repeat (run) @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [255:0] pv;
      logic [7:0]   win[$];
      logic [47:0]  base;
      logic [63:0]  len_w;
      logic [63:0]  base_w;
      logic [63:0]  mode_w;
      logic         mode;
      bit           embed;
      bit           open_end;
      int           phase;
      int           phase_items;
      int           len;
      int           wlen;
      int           pos;
      int           span;
      int           copies;
      int           sel;
      int           c;
      int           i;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(negedge clock);

      // Reset values: one-byte pattern 0x00, base 0, first match.
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      wait_idle();

      // Pattern A5 5A C3 with junk in unused bits of most registers; the
      // base sits just below the top so the first match start wraps to 0.
      pv        = '0;
      pv[63:0]  = 64'h1234_5678_9AC3_5AA5;
      pv[255:192] = 64'hFF00_0000_0000_0000;
      load_config(pv, 64'hFFFF_FFFF_FFFF_FFE3, 64'hABCD_FFFF_FFFF_FFFE,
                  64'hFFFF_FFFF_FFFF_FFFE);
      // first match reported at once, rest of the window dropped
      send_item(8'h11, 1'b0);
      send_item(8'h22, 1'b0);
      send_item(8'hA5, 1'b0);
      send_item(8'h5A, 1'b0);
      send_item(8'hC3, 1'b0);
      send_item(8'hA5, 1'b0);
      send_item(8'h00, 1'b1);
      // match completing on the end byte
      send_item(8'hA5, 1'b0);
      send_item(8'h5A, 1'b0);
      send_item(8'hC3, 1'b1);
      wait_idle();

      // Last-match mode: two hits, the later one reported; then a miss.
      load_config(pv, 64'd3, 64'h10, 64'd1);
      send_item(8'hA5, 1'b0);
      send_item(8'h5A, 1'b0);
      send_item(8'hC3, 1'b0);
      send_item(8'hA5, 1'b0);
      send_item(8'h5A, 1'b0);
      send_item(8'hC3, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      wait_idle();

      // Zero length never matches.
      load_config('0, 64'd0, 64'd0, 64'd0);
      send_item(8'h00, 1'b1);
      wait_idle();

      // Mode switched to first match in the middle of a window.
      pv       = '0;
      pv[7:0]  = 8'h7E;
      load_config(pv, 64'd1, 64'h10, 64'd1);
      send_item(8'h7E, 1'b0);
      send_item(8'h00, 1'b0);
      wait_idle();
      write_reg(REG_FIND_LAST, 64'd0);
      settle_config();
      send_item(8'h7E, 1'b0);
      send_item(8'h00, 1'b1);
      wait_idle();

      // Backpressure: every item closes a window, so every item gives a
      // result; hold the receiver off while the sender keeps going.
      load_config({8{32'($urandom)}}, 64'd1, 64'd0, 64'd1);
      sender_gaps = 1'b0;
      long_hold   = 1'b1;
      for (i = 0; i < PRESSURE_ITEMS; i++) send_item(8'($urandom), 1'b1);
      wait_idle();

      // Random phases: fresh registers each time, windows mostly carrying
      // whole copies of the pattern, some broken copies and plain noise.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         for (i = 0; i < 4; i++) alphabet[i] = 8'($urandom);
         sender_gaps  = (phase % 3) != 2;
         rsp_stall_on = (phase % 4) != 3;
         for (i = 0; i < 8; i++) pv[i*32 +: 32] = $urandom;
         sel = $urandom_range(0, 15);
         if (sel == 0) len = 0;
         else if (sel <= 2) len = 31;
         else if (sel <= 5) len = $urandom_range(7, 30);
         else len = $urandom_range(1, 6);
         sel = $urandom_range(0, 3);
         if (sel == 0) base = '0;
         else if (sel == 1) base = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 200));
         else base = {16'($urandom), 32'($urandom)};
         mode = 1'($urandom);
         // Pin the extremes on the first two phases.
         if (phase == 0) begin
            len  = 31;
            pv   = '1;
            base = '1;
            mode = 1'b1;
         end else if (phase == 1) begin
            len  = 1;
            pv   = '0;
            base = '0;
            mode = 1'b0;
         end
         if (phase > 1)
            for (i = 0; i < len; i++) pv[i*8 +: 8] = pick_byte();
         len_w       = {$urandom, $urandom};
         len_w[4:0]  = 5'(len);
         base_w      = {16'($urandom), base};
         mode_w      = {$urandom, $urandom};
         mode_w[0]   = mode;
         wait_idle();
         load_config(pv, len_w, base_w, mode_w);

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            embed = (len != 0) && ($urandom_range(0, 9) < 7);
            wlen  = $urandom_range(1, 12) + (embed ? 2 * len : 0);
            win.delete();
            for (i = 0; i < wlen; i++) win.push_back(pick_byte());
            if (embed) begin
               copies = $urandom_range(1, 2);
               for (c = 0; c < copies; c++) begin
                  pos  = $urandom_range(0, wlen - len);
                  span = ($urandom_range(0, 9) == 0) ? len - 1 : len;
                  for (i = 0; i < span; i++) win[pos + i] = pv[i*8 +: 8];
               end
            end
            // Sometimes leave the last window open across the next
            // register change.
            open_end = (phase_items + wlen >= PHASE_ITEMS) && ($urandom_range(0, 2) == 0);
            for (i = 0; i < wlen; i++) send_item(win[i], (i == wlen - 1) && !open_end);
            phase_items += wlen;
         end
      end

      wait_idle();
      drain_done <= 1'b1;
      repeat (2) @(negedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
